### hdl/npc_pkg.sv
package npc_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);

    localparam int COMP_W = 6;
    localparam int SQ_W   = 2 * COMP_W;
    localparam int DIST_W = 25;
    localparam int IDX_W  = 8;

    localparam logic [DIST_W-1:0] WEIGHT_G = DIST_W'(59 * 59);
    localparam logic [DIST_W-1:0] WEIGHT_R = DIST_W'(30 * 30);
    localparam logic [DIST_W-1:0] WEIGHT_B = DIST_W'(11 * 11);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
    } t_rgb;

    localparam int RGB_W = $bits(t_rgb);

endpackage

### hdl/npc_ram.sv
module npc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/nearest_palette_color_unit.sv
// Weighted nearest palette color search. A write transfer (tuser 0) stores one 6-bit
// red/green/blue palette entry and returns nothing. A query transfer (tuser 1) scans
// entries 1 to 255 through the palette memory's single read port, one entry per cycle,
// into a five-stage distance pipeline (read, squares, weights, sum, compare); once the
// pipeline has drained, the result is loaded into the output register, after any
// previous result that still waits on the output has been taken. The result register
// holds the lowest index with the smallest 3481*dg^2 + 900*dr^2 + 121*db^2 and that
// distance. Entries never written since reset read as black through per-entry valid
// bits, so there is no clearing pass after reset.
module nearest_palette_color_unit
    import npc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // entry_index[7:0], red[13:8], green[19:14], blue[25:20], zero[31:26]
    input  logic [31:0] i_s_axis_tdata,
    // func[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // best_index[7:0], best_distance[32:8], zero[39:33]
    output logic [39:0] o_m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    localparam logic [PAL_AW-1:0] LAST_ADDR  = PAL_AW'(PAL_ENTRIES - 1);
    localparam logic [PAL_AW-1:0] FIRST_ADDR = PAL_AW'(1);

    t_state r_state;

    logic [IDX_W-1:0]  in_index;
    t_rgb              in_rgb;
    logic              in_xfer;
    logic              wr_en;
    logic [PAL_AW-1:0] wr_addr;
    logic              rd_en;
    t_rgb              rd_data;

    logic [PAL_ENTRIES-1:0] r_valid;
    t_rgb                   r_query;
    logic [PAL_AW-1:0]      r_addr;

    // pipeline control and payload
    logic [4:1]        r_pv;
    logic [PAL_AW-1:0] r_idx1, r_idx2, r_idx3, r_idx4;
    logic              r_ent_vld1;
    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
    logic [DIST_W-1:0] r_w_r, r_w_g, r_w_b;
    logic [DIST_W-1:0] r_dist;

    t_rgb              ent;
    logic [COMP_W-1:0] d_r, d_g, d_b;

    logic              r_found;
    logic [PAL_AW-1:0] r_best_idx;
    logic [DIST_W-1:0] r_best_dist;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [DIST_W-1:0] r_out_dist;

    assign in_index = i_s_axis_tdata[7:0];
    assign in_rgb.r = i_s_axis_tdata[13:8];
    assign in_rgb.g = i_s_axis_tdata[19:14];
    assign in_rgb.b = i_s_axis_tdata[25:20];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    assign wr_en   = in_xfer && (i_s_axis_tuser == FUNC_WRITE)
                     && (32'(in_index) < 32'(PAL_ENTRIES));
    assign wr_addr = PAL_AW'(in_index);
    assign rd_en   = (r_state == S_SCAN);

    npc_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PAL_ENTRIES)
    ) u_pal_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (in_rgb),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    // never-written entries read as black
    assign ent = r_ent_vld1 ? rd_data : '0;

    assign d_r = (ent.r >= r_query.r) ? (ent.r - r_query.r) : (r_query.r - ent.r);
    assign d_g = (ent.g >= r_query.g) ? (ent.g - r_query.g) : (r_query.g - ent.g);
    assign d_b = (ent.b >= r_query.b) ? (ent.b - r_query.b) : (r_query.b - ent.b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[3:1], rd_en};
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1     <= r_addr;
        r_ent_vld1 <= r_valid[r_addr];

        r_idx2 <= r_idx1;
        r_sq_r <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b <= SQ_W'(d_b) * SQ_W'(d_b);

        r_idx3 <= r_idx2;
        r_w_r  <= DIST_W'(r_sq_r) * WEIGHT_R;
        r_w_g  <= DIST_W'(r_sq_g) * WEIGHT_G;
        r_w_b  <= DIST_W'(r_sq_b) * WEIGHT_B;

        r_idx4 <= r_idx3;
        r_dist <= r_w_g + r_w_r + r_w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= FIRST_ADDR;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            // compare stage, strict less keeps the lowest index on ties
            if (r_pv[4] && (!r_found || (r_dist < r_best_dist))) begin
                r_found     <= 1'b1;
                r_best_dist <= r_dist;
                r_best_idx  <= r_idx4;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_s_axis_tuser == FUNC_QUERY)) begin
                        r_query <= in_rgb;
                        r_addr  <= FIRST_ADDR;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + PAL_AW'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_pv == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= IDX_W'(r_best_idx);
                        r_out_dist  <= r_best_dist;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_dist, r_out_idx};

endmodule

### tb/tb_top.sv
module tb_top;
    import npc_pkg::*;

    typedef struct {
        logic              func;
        logic [IDX_W-1:0]  idx;
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
        bit                hold;
    } t_cmd;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
    } t_match;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_vld = 1'b0;
    logic        s_rdy;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_vld;
    logic        m_rdy = 1'b0;
    logic [39:0] m_tdata;

    t_cmd   cmd_q[$];
    t_match match_q[$];
    t_rgb   palette_mirror[PAL_ENTRIES];
    t_rgb   gen_palette[PAL_ENTRIES];
    bit     s_fire = 1'b0;
    int     cycle_cnt = 0;
    int     err_cnt = 0;

    nearest_palette_color_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_vld),
        .o_s_axis_tready (s_rdy),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_vld),
        .i_m_axis_tready (m_rdy),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #40_000_000;
        $display("[nearest_palette_color_unit] ERROR");
        $finish;
    end

    // lowest index in 1..N-1 with the smallest weighted distance
    function automatic t_match nearest_search(t_rgb q);
        t_match      best;
        int unsigned dr, dg, db, d;
        bit          found;
        found = 0;
        best.idx = '0;
        best.distance = '0;
        for (int i = 1; i < PAL_ENTRIES; i++) begin
            dr = (palette_mirror[i].r >= q.r) ? palette_mirror[i].r - q.r
                                              : q.r - palette_mirror[i].r;
            dg = (palette_mirror[i].g >= q.g) ? palette_mirror[i].g - q.g
                                              : q.g - palette_mirror[i].g;
            db = (palette_mirror[i].b >= q.b) ? palette_mirror[i].b - q.b
                                              : q.b - palette_mirror[i].b;
            d = int'(WEIGHT_G) * dg * dg + int'(WEIGHT_R) * dr * dr
              + int'(WEIGHT_B) * db * db;
            if (!found || d < best.distance) begin
                found = 1;
                best.distance = d[DIST_W-1:0];
                best.idx = i[IDX_W-1:0];
            end
        end
        return best;
    endfunction

    function automatic logic [COMP_W-1:0] rand_comp();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return COMP_W'($urandom_range(63));
    endfunction

    function automatic logic [COMP_W-1:0] nudge(logic [COMP_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(2)) - 1;
        if (v < 0) v = 0;
        if (v > 63) v = 63;
        return v[COMP_W-1:0];
    endfunction

    task automatic add_write(int idx, int r, int g, int b, bit hold = 0);
        t_cmd c;
        c.func = FUNC_WRITE;
        c.idx = IDX_W'(idx);
        c.r = COMP_W'(r);
        c.g = COMP_W'(g);
        c.b = COMP_W'(b);
        c.hold = hold;
        cmd_q.push_back(c);
        gen_palette[c.idx] = '{r: c.r, g: c.g, b: c.b};
    endtask

    task automatic add_query(int r, int g, int b, int idx, bit hold = 0);
        t_cmd c;
        c.func = FUNC_QUERY;
        c.idx = IDX_W'(idx);
        c.r = COMP_W'(r);
        c.g = COMP_W'(g);
        c.b = COMP_W'(b);
        c.hold = hold;
        cmd_q.push_back(c);
    endtask

    // sender side and receiver ready, both changed on the falling edge
    always @(negedge i_clk) begin : drive
        t_cmd c;
        logic nv;
        logic rdy;
        bit   calm;
        calm = (cycle_cnt >= 30000) && (cycle_cnt < 60000);
        rdy = calm || ($urandom_range(99) >= 13);
        nv = s_vld;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!s_vld || s_fire) begin
            nv = 1'b0;
            if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 13)
                && !(cmd_q[0].hold && match_q.size() != 0)) begin
                c = cmd_q.pop_front();
                nv = 1'b1;
                s_tdata <= {6'b0, c.b, c.g, c.r, c.idx};
                s_tuser <= c.func;
            end
        end
        s_vld <= nv;
        m_rdy <= rdy;
    end

    always @(posedge i_clk) begin : watch
        t_rgb             col;
        logic [IDX_W-1:0] widx;
        t_match           want;
        cycle_cnt++;
        s_fire = i_rst_n && s_vld && s_rdy;
        if (s_fire) begin
            widx = s_tdata[7:0];
            col = '{r: s_tdata[13:8], g: s_tdata[19:14], b: s_tdata[25:20]};
            if (s_tuser == FUNC_WRITE) begin
                if (int'(widx) < PAL_ENTRIES) palette_mirror[widx] = col;
            end else begin
                match_q.push_back(nearest_search(col));
            end
        end
        if (i_rst_n && m_vld && m_rdy) begin
            if (match_q.size() == 0) begin
                $error("result transfer with nothing pending: tdata %h", m_tdata);
                err_cnt++;
            end else begin
                want = match_q.pop_front();
                if (m_tdata[7:0] !== want.idx) begin
                    $error("best_index expected %0d actual %0d", want.idx, m_tdata[7:0]);
                    err_cnt++;
                end
                if (m_tdata[32:8] !== want.distance) begin
                    $error("best_distance expected %0d actual %0d", want.distance,
                           m_tdata[32:8]);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : stim
        int   pick;
        t_rgb p;
        for (int i = 0; i < PAL_ENTRIES; i++) begin
            palette_mirror[i] = '0;
            gen_palette[i] = '0;
        end

        // all black after reset: ties go to entry 1
        add_query(0, 0, 0, 255);
        add_query(63, 63, 63, 170);
        // entry 0 never takes part
        add_write(0, 63, 63, 63);
        add_query(63, 63, 63, 85);
        add_write(255, 63, 63, 63);
        add_query(63, 63, 63, 0, 1);
        add_write(200, 63, 63, 63);
        add_query(63, 63, 63, 200);
        add_write(1, 10, 20, 30);
        add_write(2, 10, 20, 30);
        add_query(10, 20, 30, 2);
        add_query(11, 20, 30, 1);
        add_write(3, 0, 63, 0);
        add_query(0, 63, 0, 3);
        add_write(128, 32, 32, 32);
        add_write(127, 31, 31, 31);
        add_query(32, 32, 32, 127);
        add_write(64, 0, 0, 63);
        add_query(0, 0, 63, 15, 1);
        add_write(1, 63, 0, 63);
        add_query(63, 0, 62, 240);

        for (int n = 0; n < 1500; n++) begin
            if ($urandom_range(99) < 55) begin
                add_write($urandom_range(255), rand_comp(), rand_comp(), rand_comp(),
                          $urandom_range(299) == 0);
            end else begin
                pick = $urandom_range(2);
                p = gen_palette[$urandom_range(255)];
                if (pick == 0)
                    add_query(rand_comp(), rand_comp(), rand_comp(), $urandom_range(255),
                              $urandom_range(299) == 0);
                else if (pick == 1)
                    add_query(p.r, p.g, p.b, $urandom_range(255));
                else
                    add_query(nudge(p.r), nudge(p.g), nudge(p.b), $urandom_range(255));
            end
        end

        while (!i_rst_n || cmd_q.size() != 0 || s_vld) @(posedge i_clk);
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[nearest_palette_color_unit] OK");
        end else begin
            $display("[nearest_palette_color_unit] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hdl/npc_pkg.sv
hdl/npc_ram.sv
hdl/nearest_palette_color_unit.sv
tb/tb_top.sv
